FILE: src/brq_pkg.sv
// Package: shared types and constants for the broadcast ring queue.
package brq_pkg;

	localparam int SLOTS   = 16;
	localparam int READERS = 16;

	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_CLAIM   = 2'd2;
	localparam logic [1:0] KIND_RELEASE = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
	localparam logic [2:0] ST_NO_READER  = 3'd3;
	localparam logic [2:0] ST_OVERWRITE  = 3'd4;

	localparam logic [32:0] HEADER_BYTES = 33'd20;

	localparam int IN_W  = 168;
	localparam int OUT_W = 240;

	// Classified command passed from front to back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  reader_id;
		logic        too_large;
		logic [31:0] payload_len;
		logic [63:0] payload_word;
		logic [63:0] stamp;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  granted_reader;
		logic [3:0]  ring_pos;
		logic [31:0] out_len;
		logic [63:0] out_sequence;
		logic [63:0] out_stamp;
		logic [63:0] out_payload;
	} res_t;

endpackage

FILE: src/broadcast_ring_queue_unit.sv
// Top level: broadcast ring queue with front queue and back executor.
// channel   | direction | content
// s_axis    | in        | tuser: kind; tdata: reader_id, payload_len, payload_word, stamp
// m_axis    | out       | tdata: status, granted_reader, ring_pos, out_len, seq, stamp, payload
// cfg       | in        | slot_bytes register write
// Back end: writes, claims, releases and empty reads go IDLE then OUT; other reads
// add MEM (position lookup, then registered slot memory read). A 2-entry queue decouples input.
// Reset clears counts, reader positions and claims; slot contents start undefined.
// A stalled result holds the back end; the front queue keeps accepting until full.
module broadcast_ring_queue_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [1:0]   s_axis_tuser,  // kind
	input  logic [167:0] s_axis_tdata,  // reader_id, payload_len, payload_word, stamp
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [239:0] m_axis_tdata,  // status, granted_reader, ring_pos, out_len,
	                                    // out_sequence, out_stamp, out_payload
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	import brq_pkg::*;

	logic [31:0] slot_bytes_q;
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	res_t        res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= 32'd4096;
		end else if (cfg_valid) begin
			slot_bytes_q <= cfg_data;
		end
	end

	brq_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_data(s_axis_tdata),
		.slot_bytes(slot_bytes_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	brq_back u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {5'd0, res.out_payload, res.out_stamp, res.out_sequence,
		res.out_len, res.ring_pos, res.granted_reader, res.status};
endmodule

FILE: src/brq_front.sv
// Front end: accepts items, checks write length, queues commands.
module brq_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_kind,
	input  logic [brq_pkg::IN_W-1:0] in_data,
	input  logic [31:0]           slot_bytes,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output brq_pkg::cmd_t         cmd
);
	import brq_pkg::*;

	cmd_t        q_q [2];
	logic [1:0]  cnt_q;
	logic        wp_q, rp_q;
	cmd_t        c;
	logic        push, pop;

	always_comb begin
		c.kind         = in_kind;
		c.reader_id    = in_data[3:0];
		c.payload_len  = in_data[35:4];
		c.payload_word = in_data[99:36];
		c.stamp        = in_data[163:100];
		c.too_large    = ({1'b0, in_data[35:4]} + HEADER_BYTES) > {1'b0, slot_bytes};
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: src/brq_back.sv
// Back end: executes commands against the ring and reader state.
module brq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  brq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output brq_pkg::res_t res
);
	import brq_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MEM  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [31:0] mem_len [SLOTS];
	logic [63:0] mem_seq [SLOTS];
	logic [63:0] mem_stamp [SLOTS];
	logic [63:0] mem_pay [SLOTS];
	logic [63:0] pos_q [READERS];
	logic [READERS-1:0] claimed_q;
	logic [63:0] wcount_q;
	logic [1:0]  state_q;
	cmd_t        cmd_q;
	logic [63:0] rpos_q;
	logic [SW-1:0] rslot_q;
	logic [31:0] rd_len_q;
	logic [63:0] rd_seq_q, rd_stamp_q, rd_pay_q;
	res_t        res_q;

	logic        rid_ok;
	logic [RW-1:0] rid;
	logic [63:0] p, diff, eff;
	logic        found;
	logic [RW-1:0] free_id;
	logic        idle_mem;
	res_t        idle_res;
	res_t        mem_res;

	assign rid    = cmd.reader_id[RW-1:0];
	assign rid_ok = ({28'd0, cmd.reader_id} < READERS);
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res = res_q;

	always_comb begin
		found   = 1'b0;
		free_id = '0;
		for (int i = READERS - 1; i >= 0; i--) begin
			if (!claimed_q[i]) begin
				found   = 1'b1;
				free_id = RW'(i);
			end
		end
		p    = pos_q[rid];
		diff = wcount_q - p;
		eff  = (diff > 64'(SLOTS)) ? wcount_q - 64'(SLOTS) : p;
		idle_mem = (cmd.kind == KIND_READ) && rid_ok && (p < wcount_q);

		idle_res = '0;
		unique case (cmd.kind)
			KIND_WRITE: begin
				if (cmd.too_large) idle_res.status = ST_TOO_LARGE;
				else idle_res.ring_pos = 4'(wcount_q[SW-1:0]);
			end
			KIND_READ: begin
				if (!rid_ok || p >= wcount_q) idle_res.status = ST_EMPTY;
			end
			KIND_CLAIM: begin
				if (found) idle_res.granted_reader = 4'(free_id);
				else idle_res.status = ST_NO_READER;
			end
			default: ;
		endcase

		mem_res = '0;
		mem_res.ring_pos = 4'(rslot_q);
		if (rd_seq_q != rpos_q) begin
			mem_res.status = ST_OVERWRITE;
		end else begin
			mem_res.out_len      = rd_len_q;
			mem_res.out_sequence = rd_seq_q;
			mem_res.out_stamp    = rd_stamp_q;
			mem_res.out_payload  = rd_pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.kind == KIND_WRITE && !cmd.too_large) begin
			mem_len[wcount_q[SW-1:0]]   <= cmd.payload_len;
			mem_seq[wcount_q[SW-1:0]]   <= wcount_q;
			mem_stamp[wcount_q[SW-1:0]] <= cmd.stamp;
			mem_pay[wcount_q[SW-1:0]]   <= cmd.payload_word;
		end
		rd_len_q   <= mem_len[eff[SW-1:0]];
		rd_seq_q   <= mem_seq[eff[SW-1:0]];
		rd_stamp_q <= mem_stamp[eff[SW-1:0]];
		rd_pay_q   <= mem_pay[eff[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wcount_q  <= '0;
			claimed_q <= '0;
			for (int i = 0; i < READERS; i++) pos_q[i] <= '0;
			res_q     <= '0;
			cmd_q     <= '0;
			rpos_q    <= '0;
			rslot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_q <= idle_res;
						cmd_q <= cmd;
						if (idle_mem) begin
							rpos_q  <= eff;
							rslot_q <= eff[SW-1:0];
							state_q <= S_MEM;
						end else begin
							state_q <= S_OUT;
						end
						unique case (cmd.kind)
							KIND_WRITE: begin
								if (!cmd.too_large) wcount_q <= wcount_q + 64'd1;
							end
							KIND_CLAIM: begin
								if (found) begin
									claimed_q[free_id] <= 1'b1;
									pos_q[free_id] <= wcount_q;
								end
							end
							KIND_RELEASE: begin
								if (rid_ok) claimed_q[rid] <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_MEM: begin
					res_q <= mem_res;
					if (rd_seq_q != rpos_q) begin
						pos_q[cmd_q.reader_id[RW-1:0]] <= wcount_q - 64'(SLOTS);
					end else begin
						pos_q[cmd_q.reader_id[RW-1:0]] <= rpos_q + 64'd1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
